// ===== rtl/lga_pkg.sv =====
// Shared types, constants and codes for the landmark gating associator.
`timescale 1ns / 1ps

package lga_pkg;

  localparam int MAP_DEPTH  = 1024;
  localparam int COORD_BITS = 16;

  localparam int ADDR_W   = (MAP_DEPTH > 1) ? $clog2(MAP_DEPTH) : 1;
  localparam int CNT_W    = $clog2(MAP_DEPTH + 1);
  localparam int POS_W    = 3 * COORD_BITS;
  localparam int SQ_W     = 2 * COORD_BITS;
  localparam int SUM_W    = SQ_W + 2;
  localparam int DIST_W   = 16;
  localparam int GATE_W   = 2 * DIST_W;
  localparam int CMP_W    = (SUM_W > GATE_W) ? SUM_W : GATE_W;
  localparam int PIX_W    = 12;
  localparam int ID_W     = 10;
  localparam int STATUS_W = 2;

  localparam logic [DIST_W-1:0] DIST_RESET = 16'd50;

  // Result status codes.
  localparam logic [STATUS_W-1:0] STATUS_MATCH = 2'd0;
  localparam logic [STATUS_W-1:0] STATUS_ADDED = 2'd1;
  localparam logic [STATUS_W-1:0] STATUS_FULL  = 2'd2;

  // Configuration port.
  localparam int PADDR_W = 3;
  localparam int PDATA_W = 32;
  localparam int REG_IDX_W = PADDR_W - 2;
  localparam logic [REG_IDX_W-1:0] REG_MATCH_DIST = 1'b0;

  typedef struct packed {
    logic signed [COORD_BITS-1:0] pos_x;
    logic signed [COORD_BITS-1:0] pos_y;
    logic signed [COORD_BITS-1:0] pos_z;
    logic [PIX_W-1:0]             pixel_u;
    logic [PIX_W-1:0]             pixel_v;
  } in_item_t;

  typedef struct packed {
    logic [ID_W-1:0]     landmark_id;
    logic [STATUS_W-1:0] status;
    logic [PIX_W-1:0]    out_pixel_u;
    logic [PIX_W-1:0]    out_pixel_v;
  } out_item_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_RESULT
  } state_t;

  typedef struct packed {
    logic start;
    logic scan;
    logic mark_match;
    logic append;
    logic mark_full;
    logic load_out;
  } ctrl_cmd_t;

  typedef struct packed {
    logic hit;
    logic scan_end;
    logic map_full;
    logic out_free;
  } dp_status_t;

endpackage

// ===== rtl/lga_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps

module lga_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                                       clk,
  input  logic                                       we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                           wdata,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                           rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== rtl/lga_ctrl.sv =====
// Controller state machine: accepts a request, runs the map scan and delivers the result.
`timescale 1ns / 1ps

module lga_ctrl (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_stall,
  input  lga_pkg::dp_status_t stat,
  output lga_pkg::ctrl_cmd_t  cmd
);

  lga_pkg::state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= lga_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd        = '0;
    in_stall   = 1'b1;
    unique case (state)
      lga_pkg::ST_IDLE: begin
        in_stall = 1'b0;
        if (in_valid) begin
          cmd.start  = 1'b1;
          state_next = lga_pkg::ST_SCAN;
        end
      end
      lga_pkg::ST_SCAN: begin
        cmd.scan = 1'b1;
        // The compare stage sees entries in map order, so the first hit is the earliest match.
        if (stat.hit) begin
          cmd.mark_match = 1'b1;
          state_next     = lga_pkg::ST_RESULT;
        end else if (stat.scan_end) begin
          if (stat.map_full) begin
            cmd.mark_full = 1'b1;
          end else begin
            cmd.append = 1'b1;
          end
          state_next = lga_pkg::ST_RESULT;
        end
      end
      lga_pkg::ST_RESULT: begin
        if (stat.out_free) begin
          cmd.load_out = 1'b1;
          state_next   = lga_pkg::ST_IDLE;
        end
      end
      default: begin
        state_next = lga_pkg::ST_IDLE;
      end
    endcase
  end

endmodule

// ===== rtl/lga_dp.sv =====
// Datapath: map memory, scan pipeline with squared-distance gate, result and output registers.
`timescale 1ns / 1ps

module lga_dp (
  input  logic                            clk,
  input  logic                            rst,
  input  lga_pkg::in_item_t               in_data,
  input  logic [lga_pkg::DIST_W-1:0]      match_dist,
  input  lga_pkg::ctrl_cmd_t              cmd,
  output lga_pkg::dp_status_t             stat,
  output logic                            out_valid,
  input  logic                            out_stall,
  output lga_pkg::out_item_t              out_data
);

  function automatic logic [lga_pkg::COORD_BITS-1:0] abs_diff(
    input logic signed [lga_pkg::COORD_BITS-1:0] a,
    input logic signed [lga_pkg::COORD_BITS-1:0] b
  );
    logic signed [lga_pkg::COORD_BITS:0] d;
    d = {a[lga_pkg::COORD_BITS-1], a} - {b[lga_pkg::COORD_BITS-1], b};
    if (d[lga_pkg::COORD_BITS]) begin
      return lga_pkg::COORD_BITS'(-d);
    end else begin
      return d[lga_pkg::COORD_BITS-1:0];
    end
  endfunction

  lga_pkg::in_item_t               item;
  logic [lga_pkg::GATE_W-1:0]      gate;
  logic [lga_pkg::CNT_W-1:0]       count;
  logic [lga_pkg::CNT_W-1:0]       rd_idx;
  logic                            rd_issue;

  logic                            s1_valid;
  logic [lga_pkg::ADDR_W-1:0]      s1_idx;
  logic [lga_pkg::POS_W-1:0]       ram_rdata;

  logic                            s2_valid;
  logic [lga_pkg::ADDR_W-1:0]      s2_idx;
  logic [lga_pkg::COORD_BITS-1:0]  ax, ay, az;

  logic                            s3_valid;
  logic [lga_pkg::ADDR_W-1:0]      s3_idx;
  logic [lga_pkg::SQ_W-1:0]        qx, qy, qz;
  logic [lga_pkg::SUM_W-1:0]       sum;

  logic [lga_pkg::ID_W-1:0]        res_id;
  logic [lga_pkg::STATUS_W-1:0]    res_status;

  logic signed [lga_pkg::COORD_BITS-1:0] mx, my, mz;

  assign rd_issue = cmd.scan && (rd_idx < count);

  lga_ram #(
    .WIDTH(lga_pkg::POS_W),
    .DEPTH(lga_pkg::MAP_DEPTH)
  ) u_map (
    .clk  (clk),
    .we   (cmd.append),
    .waddr(count[lga_pkg::ADDR_W-1:0]),
    .wdata({item.pos_x, item.pos_y, item.pos_z}),
    .raddr(rd_idx[lga_pkg::ADDR_W-1:0]),
    .rdata(ram_rdata)
  );

  assign mx = $signed(ram_rdata[3*lga_pkg::COORD_BITS-1:2*lga_pkg::COORD_BITS]);
  assign my = $signed(ram_rdata[2*lga_pkg::COORD_BITS-1:lga_pkg::COORD_BITS]);
  assign mz = $signed(ram_rdata[lga_pkg::COORD_BITS-1:0]);

  assign sum = lga_pkg::SUM_W'(qx) + lga_pkg::SUM_W'(qy) + lga_pkg::SUM_W'(qz);

  assign stat.hit      = s3_valid &&
                         (lga_pkg::CMP_W'(sum) < lga_pkg::CMP_W'(gate));
  assign stat.scan_end = (rd_idx >= count) && !s1_valid && !s2_valid && !s3_valid;
  assign stat.map_full = (count == lga_pkg::CNT_W'(lga_pkg::MAP_DEPTH));
  assign stat.out_free = !out_valid || !out_stall;

  // Item, gate and scan pointer are set up when a request is taken.
  always_ff @(posedge clk) begin
    if (cmd.start) begin
      item <= in_data;
      gate <= lga_pkg::GATE_W'(match_dist) * lga_pkg::GATE_W'(match_dist);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rd_idx   <= '0;
      s1_valid <= 1'b0;
      s2_valid <= 1'b0;
      s3_valid <= 1'b0;
    end else if (cmd.start) begin
      rd_idx   <= '0;
      s1_valid <= 1'b0;
      s2_valid <= 1'b0;
      s3_valid <= 1'b0;
    end else begin
      if (rd_issue) begin
        rd_idx <= rd_idx + 1'b1;
      end
      s1_valid <= rd_issue;
      s2_valid <= s1_valid;
      s3_valid <= s2_valid;
    end
  end

  always_ff @(posedge clk) begin
    s1_idx <= rd_idx[lga_pkg::ADDR_W-1:0];
    s2_idx <= s1_idx;
    s3_idx <= s2_idx;
    ax     <= abs_diff(mx, item.pos_x);
    ay     <= abs_diff(my, item.pos_y);
    az     <= abs_diff(mz, item.pos_z);
    qx     <= lga_pkg::SQ_W'(ax) * lga_pkg::SQ_W'(ax);
    qy     <= lga_pkg::SQ_W'(ay) * lga_pkg::SQ_W'(ay);
    qz     <= lga_pkg::SQ_W'(az) * lga_pkg::SQ_W'(az);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
    end else if (cmd.append) begin
      count <= count + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.mark_match) begin
      res_id     <= lga_pkg::ID_W'(s3_idx);
      res_status <= lga_pkg::STATUS_MATCH;
    end else if (cmd.append) begin
      res_id     <= lga_pkg::ID_W'(count);
      res_status <= lga_pkg::STATUS_ADDED;
    end else if (cmd.mark_full) begin
      res_id     <= '0;
      res_status <= lga_pkg::STATUS_FULL;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.load_out) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      out_data.landmark_id <= res_id;
      out_data.status      <= res_status;
      out_data.out_pixel_u <= item.pixel_u;
      out_data.out_pixel_v <= item.pixel_v;
    end
  end

endmodule

// ===== rtl/landmark_gating_associator_core.sv =====
// A request is answered after a scan of the N stored landmarks (N at most MAP_DEPTH); the
// single read port of the map memory scans one entry a cycle. A match stops the scan early.
// One request is in work at a time; a new one is taken while the last result waits in the
// output register.
// Reset clears the landmark count, the control state and sets the gate distance to 50 mm;
// the map memory is not cleared, as only entries below the count are ever read.
`timescale 1ns / 1ps

module landmark_gating_associator_core (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  lga_pkg::in_item_t             in_data,
  output logic                          out_valid,
  input  logic                          out_stall,
  output lga_pkg::out_item_t            out_data,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [lga_pkg::PADDR_W-1:0]   paddr,
  input  logic [lga_pkg::PDATA_W-1:0]   pwdata,
  output logic [lga_pkg::PDATA_W-1:0]   prdata,
  output logic                          pready
);

  logic [lga_pkg::DIST_W-1:0]    match_dist;
  logic [lga_pkg::REG_IDX_W-1:0] reg_idx;
  logic                          wr_en;
  lga_pkg::ctrl_cmd_t            cmd;
  lga_pkg::dp_status_t           stat;

  assign pready  = 1'b1;
  assign reg_idx = paddr[lga_pkg::PADDR_W-1:2];
  assign wr_en   = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      match_dist <= lga_pkg::DIST_RESET;
    end else if (wr_en && (reg_idx == lga_pkg::REG_MATCH_DIST)) begin
      match_dist <= pwdata[lga_pkg::DIST_W-1:0];
    end
  end

  always_comb begin
    unique case (reg_idx)
      lga_pkg::REG_MATCH_DIST: prdata = lga_pkg::PDATA_W'(match_dist);
      default:                 prdata = '0;
    endcase
  end

  lga_ctrl u_ctrl (
    .clk     (clk),
    .rst     (rst),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .stat    (stat),
    .cmd     (cmd)
  );

  lga_dp u_dp (
    .clk       (clk),
    .rst       (rst),
    .in_data   (in_data),
    .match_dist(match_dist),
    .cmd       (cmd),
    .stat      (stat),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

endmodule
